FILE: src/comment_stripper_stream_core_defines.svh
// Assertion macros shared by the comment stripper modules.
`ifndef COMMENT_STRIPPER_STREAM_CORE_DEFINES_SVH
`define COMMENT_STRIPPER_STREAM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CSS_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define CSS_ASSERT(label, clk, rst_n, prop, msg)
`define CSS_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

FILE: src/cstrip_pkg.sv
package cstrip_pkg;

    localparam int CHAR_W = 16;

    localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_NL     = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_STR        = 4'd2,
        MODE_STR_ESC    = 4'd3,
        MODE_CHR        = 4'd4,
        MODE_CHR_ESC    = 4'd5,
        MODE_LINE       = 4'd6,
        MODE_BLOCK      = 4'd7,
        MODE_BLOCK_STAR = 4'd8
    } cstrip_mode_t;

    // one queued input: one or two characters to send
    typedef struct packed {
        logic [CHAR_W-1:0] char_a;
        logic [CHAR_W-1:0] char_b;
        logic              two;
        logic              eot;
    } cstrip_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cstrip_q_status_t;

endpackage

FILE: src/comment_stripper_stream_core.sv
// Strips // line comments and /* */ block comments from a stream of 16-bit characters,
// leaving string and character literals (with backslash escapes) untouched. A line
// comment becomes a space plus its newline, a block comment one space. One character
// is accepted per cycle while the result queue (2**FIFO_AW entries) has room; the
// output port sends one beat per cycle while m_tready is high, so a character that
// yields two beats (held slash, or newline ending a line comment) takes two output
// beats; the queue absorbs these. A beat goes from a queue entry to the output register.
// FIFO_AW ranges from 1 to 5.
module comment_stripper_stream_core #(
    parameter int FIFO_AW = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] char_code
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_char
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // text_end
);
    import cstrip_pkg::*;

    logic             push;
    logic             pop;
    cstrip_entry_t    push_entry;
    cstrip_entry_t    pop_entry;
    cstrip_q_status_t q_status;

    cstrip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    cstrip_fifo #(
        .AW (FIFO_AW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    cstrip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: src/cstrip_front.sv
`include "comment_stripper_stream_core_defines.svh"

module cstrip_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [15:0] char_code
    input  logic                     s_tlast,   // end_of_text
    input  cstrip_pkg::cstrip_q_status_t q_status,
    output logic                     push,
    output cstrip_pkg::cstrip_entry_t push_entry
);
    import cstrip_pkg::*;

    cstrip_mode_t      mode_reg;
    cstrip_mode_t      mode_next;
    logic [CHAR_W-1:0] c;
    logic              eot;
    logic              emit;
    logic              accept;

    function automatic cstrip_mode_t normal_next(input logic [CHAR_W-1:0] ch,
                                                 input logic e);
        cstrip_mode_t m;
        if (ch == CH_SLASH) begin
            m = e ? MODE_NORMAL : MODE_SLASH;
        end
        else if (ch == CH_DQUOTE) begin
            m = MODE_STR;
        end
        else if (ch == CH_SQUOTE) begin
            m = MODE_CHR;
        end
        else begin
            m = MODE_NORMAL;
        end
        return m;
    endfunction

    assign c        = s_tdata;
    assign eot      = s_tlast;
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && emit;

    always_comb
    begin
        case (mode_reg)
            MODE_SLASH:
            begin
                if (c == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end
                else if (c == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end
                else begin
                    mode_next = normal_next(c, eot);
                end
            end
            MODE_STR:
            begin
                if (c == CH_BSLASH) begin
                    mode_next = MODE_STR_ESC;
                end
                else if (c == CH_DQUOTE) begin
                    mode_next = MODE_NORMAL;
                end
                else begin
                    mode_next = MODE_STR;
                end
            end
            MODE_STR_ESC: mode_next = MODE_STR;
            MODE_CHR:
            begin
                if (c == CH_BSLASH) begin
                    mode_next = MODE_CHR_ESC;
                end
                else if (c == CH_SQUOTE) begin
                    mode_next = MODE_NORMAL;
                end
                else begin
                    mode_next = MODE_CHR;
                end
            end
            MODE_CHR_ESC: mode_next = MODE_CHR;
            MODE_LINE: mode_next = (c == CH_NL) ? MODE_NORMAL : MODE_LINE;
            MODE_BLOCK, MODE_BLOCK_STAR:
            begin
                if (mode_reg == MODE_BLOCK_STAR && c == CH_SLASH) begin
                    mode_next = MODE_NORMAL;
                end
                else begin
                    mode_next = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
                end
            end
            default: mode_next = normal_next(c, eot);
        endcase
        if (eot) begin
            mode_next = MODE_NORMAL;
        end
    end

    always_comb
    begin
        emit              = 1'b0;
        push_entry.char_a = c;
        push_entry.char_b = c;
        push_entry.two    = 1'b0;
        push_entry.eot    = eot;
        case (mode_reg)
            MODE_SLASH:
            begin
                if (c == CH_SLASH || c == CH_STAR) begin
                    emit              = eot;
                    push_entry.char_a = CH_SPACE;
                end
                else begin
                    emit              = 1'b1;
                    push_entry.char_a = CH_SLASH;
                    push_entry.two    = 1'b1;
                end
            end
            MODE_STR, MODE_STR_ESC, MODE_CHR, MODE_CHR_ESC: emit = 1'b1;
            MODE_LINE:
            begin
                push_entry.char_a = CH_SPACE;
                push_entry.char_b = CH_NL;
                if (c == CH_NL) begin
                    emit           = 1'b1;
                    push_entry.two = 1'b1;
                end
                else begin
                    emit = eot;
                end
            end
            MODE_BLOCK, MODE_BLOCK_STAR:
            begin
                push_entry.char_a = CH_SPACE;
                emit = (mode_reg == MODE_BLOCK_STAR && c == CH_SLASH) || eot;
            end
            default: emit = (c != CH_SLASH) || eot;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
        end
        else if (accept) begin
            mode_reg <= mode_next;
        end
    end

    `CSS_ASSERT(a_eot_resets_mode, clk, rst_n, accept && eot |=> mode_reg == MODE_NORMAL, "mode not normal after end of text")
    `CSS_NEVER(a_eot_always_emits, clk, rst_n, accept && eot && !emit, "final beat produced no output")

endmodule

FILE: src/cstrip_fifo.sv
`include "comment_stripper_stream_core_defines.svh"

module cstrip_fifo #(
    parameter int AW = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  cstrip_pkg::cstrip_entry_t  push_entry,
    input  logic                       pop,
    output cstrip_pkg::cstrip_entry_t  pop_entry,
    output cstrip_pkg::cstrip_q_status_t q_status
);
    import cstrip_pkg::*;

    localparam int DEPTH = 1 << AW;

    cstrip_entry_t entries_reg [DEPTH];
    logic [AW:0]   wr_ptr_reg;
    logic [AW:0]   wr_ptr_next;
    logic [AW:0]   rd_ptr_reg;
    logic [AW:0]   rd_ptr_next;

    assign q_status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_status.full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW])
                         && (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign pop_entry      = entries_reg[rd_ptr_reg[AW-1:0]];
    assign wr_ptr_next    = wr_ptr_reg + {{AW{1'b0}}, 1'b1};
    assign rd_ptr_next    = rd_ptr_reg + {{AW{1'b0}}, 1'b1};

    always_ff @(posedge clk)
    begin
        if (push) begin
            entries_reg[wr_ptr_reg[AW-1:0]] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    `CSS_NEVER(a_no_overflow, clk, rst_n, push && q_status.full, "push into full queue")
    `CSS_NEVER(a_no_underflow, clk, rst_n, pop && q_status.empty, "pop from empty queue")

endmodule

FILE: src/cstrip_back.sv
`include "comment_stripper_stream_core_defines.svh"

module cstrip_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cstrip_pkg::cstrip_entry_t    pop_entry,
    input  cstrip_pkg::cstrip_q_status_t q_status,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [15:0] out_char
    output logic                         m_tlast,   // run_end
    output logic                         m_tuser    // text_end
);
    import cstrip_pkg::*;

    logic              valid_reg;
    logic              phase_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              user_reg;
    logic              load;

    assign load = (!valid_reg || m_tready) && !q_status.empty;
    assign pop  = load && (phase_reg || !pop_entry.two);

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else begin
            if (!valid_reg || m_tready) begin
                valid_reg <= !q_status.empty;
            end
            if (load) begin
                phase_reg <= !phase_reg && pop_entry.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            char_reg <= phase_reg ? pop_entry.char_b : pop_entry.char_a;
            last_reg <= phase_reg || !pop_entry.two;
            user_reg <= pop_entry.eot && (phase_reg || !pop_entry.two);
        end
    end

    `CSS_ASSERT(a_second_after_first, clk, rst_n, phase_reg |-> valid_reg, "second beat pending without first")
    `CSS_NEVER(a_second_has_entry, clk, rst_n, phase_reg && q_status.empty, "second beat pending with empty queue")

endmodule
